// File: design/dpdc_pkg.sv
`default_nettype none
package dpdc_pkg;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      IDX_GAS_CENTER            = 3'd0,
      IDX_STEER_CENTER          = 3'd1,
      IDX_STEER_FEEDBACK_CENTER = 3'd2,
      IDX_THROTTLE_DEADBAND     = 3'd3,
      IDX_BRAKE_DEADBAND        = 3'd4,
      IDX_STEER_DEADBAND        = 3'd5,
      IDX_THROTTLE_GAIN         = 3'd6,
      IDX_STEER_GAIN            = 3'd7
   } cfg_index_type;

   localparam int SAMPLE_WIDTH = 10;
   localparam int RPM_WIDTH    = 16;
   localparam int CFG8_WIDTH   = 8;
   localparam int PWM_WIDTH    = 8;
   localparam int CSR_WIDTH    = 10;
   localparam int NUM_STAGES   = 8;

   localparam logic [9:0] GAS_CENTER_RST            = 10'd510;
   localparam logic [9:0] STEER_CENTER_RST          = 10'd508;
   localparam logic [9:0] STEER_FEEDBACK_CENTER_RST = 10'd512;
   localparam logic [7:0] THROTTLE_DEADBAND_RST     = 8'd5;
   localparam logic [7:0] BRAKE_DEADBAND_RST        = 8'd5;
   localparam logic [7:0] STEER_DEADBAND_RST        = 8'd5;
   localparam logic [7:0] THROTTLE_GAIN_RST         = 8'd1;
   localparam logic [7:0] STEER_GAIN_RST            = 8'd70;

   // Scale factors and divisors of the setpoint and feedback paths.
   localparam int THROTTLE_SP_SCALE = 100;
   localparam int BRAKE_SP_SCALE    = 250;
   localparam int GAS_SP_DIV        = 123;
   localparam int STEER_SP_SCALE    = 270;
   localparam int STEER_SP_DIV      = 246;
   localparam int PV_SCALE          = 100;
   localparam int PV_DIV            = 1023;
   localparam int PWM_SCALE         = 255;
   localparam int THROTTLE_OUT_DIV  = 100;
   localparam int STEER_OUT_DIV     = 270;
   localparam int STEER_FLIP_LIMIT  = 40;
   localparam int PWM_MAX           = 255;

   // Numerator and quotient widths, sized by the largest possible values.
   localparam int TSP_NUM_WIDTH = 17;  // 1023 * 100
   localparam int TSP_WIDTH     = 10;  // 831
   localparam int BSP_NUM_WIDTH = 18;  // 1023 * 250
   localparam int BSP_WIDTH     = 12;  // 2079
   localparam int SSP_NUM_WIDTH = 19;  // 1023 * 270
   localparam int SSP_WIDTH     = 11;  // 1122
   localparam int TPV_NUM_WIDTH = 23;  // 65535 * 100
   localparam int TPV_WIDTH     = 13;  // 6406
   localparam int SPV_NUM_WIDTH = 17;  // 1023 * 100
   localparam int SPV_WIDTH     = 7;   // 100
   localparam int TOUT_NUM_WIDTH = 26; // 831 * 255 * 255
   localparam int TOUT_WIDTH     = 20;
   localparam int SOUT_NUM_WIDTH = 27; // 1222 * 255 * 255
   localparam int SOUT_WIDTH     = 19;

   typedef struct packed {
      logic [9:0] gas_center;
      logic [9:0] steer_center;
      logic [9:0] steer_feedback_center;
      logic [7:0] throttle_deadband;
      logic [7:0] brake_deadband;
      logic [7:0] steer_deadband;
      logic [7:0] throttle_gain;
      logic [7:0] steer_gain;
   } cfg_type;

   // Load enables of the pipeline stages, front to back.
   typedef struct packed {
      logic a;
      logic b;
      logic c;
      logic d;
      logic e;
      logic f;
      logic g;
      logic o;
   } stage_en_type;

   typedef struct packed {
      logic [TSP_WIDTH-1:0] tsp;
      logic [BSP_WIDTH-1:0] bsp;
      logic [SSP_WIDTH-1:0] ssp_mag;
      logic                 ssp_neg;
      logic [TPV_WIDTH-1:0] tpv;
      logic [SPV_WIDTH-1:0] spv_mag;
      logic                 spv_neg;
      logic                 fwd;
   } front_result_type;

endpackage
`default_nettype wire

// File: design/dpdc_cdiv.sv
`default_nettype none
module dpdc_cdiv #(
   parameter int WIDTH   = 17,
   parameter int DIVISOR = 123,
   parameter int Q_WIDTH = 10
) (
   input  logic               clock,
   input  logic               en_est,
   input  logic               en_fix,
   input  logic [WIDTH-1:0]   num,
   output logic [Q_WIDTH-1:0] quot
);
   // The reciprocal is rounded down with WIDTH fraction bits, so for any
   // numerator below 2**WIDTH the estimate is the true quotient or one less.
   localparam logic [WIDTH:0]   MAGIC = (WIDTH+1)'((64'd1 << WIDTH) / DIVISOR);
   localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

   logic [2*WIDTH:0]   prod;
   logic [WIDTH-1:0]   num_ff;
   logic [Q_WIDTH-1:0] est_ff;
   logic [Q_WIDTH-1:0] quot_ff;
   logic [WIDTH-1:0]   est_w;
   logic [WIDTH-1:0]   back_prod;
   logic [WIDTH-1:0]   rem;

   assign prod      = num * MAGIC;
   assign est_w     = WIDTH'(est_ff);
   assign back_prod = est_w * DIV_W;
   assign rem       = num_ff - back_prod;

   always_ff @(posedge clock) begin
      if (en_est) begin
         num_ff <= num;
         est_ff <= prod[WIDTH +: Q_WIDTH];
      end
      if (en_fix) begin
         quot_ff <= (rem >= DIV_W) ? est_ff + Q_WIDTH'(1) : est_ff;
      end
   end

   assign quot = quot_ff;
endmodule
`default_nettype wire

// File: design/dpdc_front.sv
`default_nettype none
module dpdc_front (
   input  logic                       clock,
   input  dpdc_pkg::stage_en_type     en,
   input  dpdc_pkg::cfg_type          cfg,
   input  logic [9:0]                 gas_sample,
   input  logic [9:0]                 steer_sample,
   input  logic [9:0]                 steer_feedback,
   input  logic [15:0]                motor_rpm,
   input  logic                       forward_switch,
   output dpdc_pkg::front_result_type res
);
   import dpdc_pkg::*;

   logic signed [SAMPLE_WIDTH:0] g_diff;
   logic signed [SAMPLE_WIDTH:0] s_diff;
   logic signed [SAMPLE_WIDTH:0] f_diff;
   logic [SAMPLE_WIDTH-1:0]      g_mag;
   logic [SAMPLE_WIDTH-1:0]      s_mag;
   logic [SAMPLE_WIDTH-1:0]      f_mag;

   logic [TSP_NUM_WIDTH-1:0] tnum_a_ff;
   logic [BSP_NUM_WIDTH-1:0] bnum_a_ff;
   logic [SSP_NUM_WIDTH-1:0] snum_a_ff;
   logic [TPV_NUM_WIDTH-1:0] rnum_a_ff;
   logic [SPV_NUM_WIDTH-1:0] fnum_a_ff;
   logic [2:0]               side_a_ff;
   logic [2:0]               side_b_ff;
   logic [2:0]               side_c_ff;

   assign g_diff = signed'({1'b0, gas_sample}) - signed'({1'b0, cfg.gas_center});
   assign s_diff = signed'({1'b0, steer_sample}) - signed'({1'b0, cfg.steer_center});
   assign f_diff = signed'({1'b0, steer_feedback}) -
                   signed'({1'b0, cfg.steer_feedback_center});
   assign g_mag  = g_diff[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-g_diff) : SAMPLE_WIDTH'(g_diff);
   assign s_mag  = s_diff[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-s_diff) : SAMPLE_WIDTH'(s_diff);
   assign f_mag  = f_diff[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-f_diff) : SAMPLE_WIDTH'(f_diff);

   // Signed quotients truncate toward zero, so magnitudes are divided and
   // the signs ride alongside: {steer negative, feedback negative, forward}.
   always_ff @(posedge clock) begin
      if (en.a) begin
         tnum_a_ff <= g_diff[SAMPLE_WIDTH] ? '0 :
                      TSP_NUM_WIDTH'(g_mag) * TSP_NUM_WIDTH'(THROTTLE_SP_SCALE);
         bnum_a_ff <= g_diff[SAMPLE_WIDTH] ?
                      BSP_NUM_WIDTH'(g_mag) * BSP_NUM_WIDTH'(BRAKE_SP_SCALE) : '0;
         snum_a_ff <= SSP_NUM_WIDTH'(s_mag) * SSP_NUM_WIDTH'(STEER_SP_SCALE);
         rnum_a_ff <= TPV_NUM_WIDTH'(motor_rpm) * TPV_NUM_WIDTH'(PV_SCALE);
         fnum_a_ff <= SPV_NUM_WIDTH'(f_mag) * SPV_NUM_WIDTH'(PV_SCALE);
         side_a_ff <= {s_diff[SAMPLE_WIDTH], f_diff[SAMPLE_WIDTH], forward_switch};
      end
      if (en.b) begin
         side_b_ff <= side_a_ff;
      end
      if (en.c) begin
         side_c_ff <= side_b_ff;
      end
   end

   dpdc_cdiv #(.WIDTH(TSP_NUM_WIDTH), .DIVISOR(GAS_SP_DIV), .Q_WIDTH(TSP_WIDTH)) u_tsp_div (
      .clock(clock), .en_est(en.b), .en_fix(en.c), .num(tnum_a_ff), .quot(res.tsp)
   );

   dpdc_cdiv #(.WIDTH(BSP_NUM_WIDTH), .DIVISOR(GAS_SP_DIV), .Q_WIDTH(BSP_WIDTH)) u_bsp_div (
      .clock(clock), .en_est(en.b), .en_fix(en.c), .num(bnum_a_ff), .quot(res.bsp)
   );

   dpdc_cdiv #(.WIDTH(SSP_NUM_WIDTH), .DIVISOR(STEER_SP_DIV), .Q_WIDTH(SSP_WIDTH)) u_ssp_div (
      .clock(clock), .en_est(en.b), .en_fix(en.c), .num(snum_a_ff), .quot(res.ssp_mag)
   );

   dpdc_cdiv #(.WIDTH(TPV_NUM_WIDTH), .DIVISOR(PV_DIV), .Q_WIDTH(TPV_WIDTH)) u_tpv_div (
      .clock(clock), .en_est(en.b), .en_fix(en.c), .num(rnum_a_ff), .quot(res.tpv)
   );

   dpdc_cdiv #(.WIDTH(SPV_NUM_WIDTH), .DIVISOR(PV_DIV), .Q_WIDTH(SPV_WIDTH)) u_spv_div (
      .clock(clock), .en_est(en.b), .en_fix(en.c), .num(fnum_a_ff), .quot(res.spv_mag)
   );

   assign res.ssp_neg = side_c_ff[2];
   assign res.spv_neg = side_c_ff[1];
   assign res.fwd     = side_c_ff[0];
endmodule
`default_nettype wire

// File: design/dpdc_back.sv
`default_nettype none
module dpdc_back (
   input  logic                       clock,
   input  dpdc_pkg::stage_en_type     en,
   input  dpdc_pkg::cfg_type          cfg,
   input  dpdc_pkg::front_result_type res,
   output logic [7:0]                 throttle_pwm,
   output logic [7:0]                 brake_pump_pwm,
   output logic [7:0]                 steer_right_pwm,
   output logic [7:0]                 steer_left_pwm,
   output logic                       throttle_enable,
   output logic                       regen_brake_enable,
   output logic                       direction_forward
);
   import dpdc_pkg::*;

   typedef struct packed {
      logic [PWM_WIDTH-1:0] bpwm;
      logic                 thr_en;
      logic                 regen;
      logic                 sneg;
      logic                 fwd;
   } side_type;

   // Stage D: setpoint selection and the two deadbands.
   logic                  brake;
   logic [TSP_WIDTH-1:0]  tsp_eff;
   logic                  sp_neg;
   logic signed [11:0]    sp_mag_s;
   logic signed [11:0]    sp_s;
   logic signed [11:0]    pv_mag_s;
   logic signed [11:0]    pv_s;
   logic signed [11:0]    s_s;
   logic [10:0]           s_abs;
   logic [10:0]           s_db;
   logic signed [13:0]    e_s;
   logic signed [13:0]    tdb_s;
   logic [TSP_WIDTH-1:0]  e_db;
   side_type              side_d;

   assign brake    = res.bsp > BSP_WIDTH'(cfg.brake_deadband);
   assign tsp_eff  = brake ? '0 : res.tsp;
   // A steering setpoint above the flip limit is made negative.
   assign sp_neg   = res.ssp_neg || (res.ssp_mag > SSP_WIDTH'(STEER_FLIP_LIMIT));
   assign sp_mag_s = signed'({1'b0, res.ssp_mag});
   assign sp_s     = sp_neg ? -sp_mag_s : sp_mag_s;
   assign pv_mag_s = signed'({5'b0, res.spv_mag});
   assign pv_s     = res.spv_neg ? -pv_mag_s : pv_mag_s;
   assign s_s      = sp_s - pv_s;
   assign s_abs    = s_s[11] ? 11'(-s_s) : 11'(s_s);
   assign s_db     = (s_abs > 11'(cfg.steer_deadband)) ? s_abs - 11'(cfg.steer_deadband) : '0;

   // Only a throttle error above the deadband can give a nonzero duty;
   // everything else clamps to zero.
   assign e_s   = signed'({4'b0, tsp_eff}) - signed'({1'b0, res.tpv});
   assign tdb_s = signed'({6'b0, cfg.throttle_deadband});
   assign e_db  = (e_s > tdb_s) ? TSP_WIDTH'(e_s - tdb_s) : '0;

   assign side_d.bpwm   = (res.bsp > BSP_WIDTH'(PWM_MAX)) ? PWM_WIDTH'(PWM_MAX) :
                          res.bsp[PWM_WIDTH-1:0];
   assign side_d.thr_en = !brake && (res.tsp > TSP_WIDTH'(cfg.throttle_deadband));
   assign side_d.regen  = brake;
   assign side_d.sneg   = s_s[11];
   assign side_d.fwd    = res.fwd;

   logic [TSP_WIDTH-1:0] e_d_ff;
   logic [10:0]          s_d_ff;
   side_type             side_d_ff;

   // Stage E: gain and the PWM scale.
   logic [17:0]               tprod;
   logic [18:0]               sprod;
   logic [TOUT_NUM_WIDTH-1:0] tnum_e_ff;
   logic [SOUT_NUM_WIDTH-1:0] snum_e_ff;
   side_type                  side_e_ff;
   side_type                  side_f_ff;
   side_type                  side_g_ff;

   assign tprod = 18'(e_d_ff) * 18'(cfg.throttle_gain);
   assign sprod = 19'(s_d_ff) * 19'(cfg.steer_gain);

   logic [TOUT_WIDTH-1:0] tq;
   logic [SOUT_WIDTH-1:0] sq;
   logic [PWM_WIDTH-1:0]  smag;

   logic [PWM_WIDTH-1:0] throttle_ff;
   logic [PWM_WIDTH-1:0] brake_ff;
   logic [PWM_WIDTH-1:0] right_ff;
   logic [PWM_WIDTH-1:0] left_ff;
   logic                 thr_en_ff;
   logic                 regen_ff;
   logic                 fwd_ff;

   assign smag = (sq > SOUT_WIDTH'(PWM_MAX)) ? PWM_WIDTH'(PWM_MAX) : sq[PWM_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (en.d) begin
         e_d_ff    <= e_db;
         s_d_ff    <= s_db;
         side_d_ff <= side_d;
      end
      if (en.e) begin
         tnum_e_ff <= (TOUT_NUM_WIDTH'(tprod) * TOUT_NUM_WIDTH'(PWM_SCALE));
         snum_e_ff <= (SOUT_NUM_WIDTH'(sprod) * SOUT_NUM_WIDTH'(PWM_SCALE));
         side_e_ff <= side_d_ff;
      end
      if (en.f) begin
         side_f_ff <= side_e_ff;
      end
      if (en.g) begin
         side_g_ff <= side_f_ff;
      end
      if (en.o) begin
         throttle_ff <= (tq > TOUT_WIDTH'(PWM_MAX)) ? PWM_WIDTH'(PWM_MAX) :
                        tq[PWM_WIDTH-1:0];
         brake_ff    <= side_g_ff.bpwm;
         right_ff    <= side_g_ff.sneg ? '0 : smag;
         left_ff     <= side_g_ff.sneg ? smag : '0;
         thr_en_ff   <= side_g_ff.thr_en;
         regen_ff    <= side_g_ff.regen;
         fwd_ff      <= side_g_ff.fwd;
      end
   end

   dpdc_cdiv #(.WIDTH(TOUT_NUM_WIDTH), .DIVISOR(THROTTLE_OUT_DIV), .Q_WIDTH(TOUT_WIDTH))
   u_tout_div (
      .clock(clock), .en_est(en.f), .en_fix(en.g), .num(tnum_e_ff), .quot(tq)
   );

   dpdc_cdiv #(.WIDTH(SOUT_NUM_WIDTH), .DIVISOR(STEER_OUT_DIV), .Q_WIDTH(SOUT_WIDTH))
   u_sout_div (
      .clock(clock), .en_est(en.f), .en_fix(en.g), .num(snum_e_ff), .quot(sq)
   );

   assign throttle_pwm       = throttle_ff;
   assign brake_pump_pwm     = brake_ff;
   assign steer_right_pwm    = right_ff;
   assign steer_left_pwm     = left_ff;
   assign throttle_enable    = thr_en_ff;
   assign regen_brake_enable = regen_ff;
   assign direction_forward  = fwd_ff;
endmodule
`default_nettype wire

// File: design/deadband_p_drive_control_unit.sv
`default_nettype none
// Proportional drive controller with deadband. Each item is one control tick
// (joystick gas and steering, steering potentiometer, motor rpm, forward
// switch) and yields one result item with the throttle, brake-pump and
// steering PWM duties plus the enable and direction outputs. The block is an
// eight-stage pipeline that accepts one item per clock cycle unless req_stall is
// high. Each item passes through stages a to g and the output stage o before its
// result shows on the rsp_ port. The constant divisions are the long paths,
// each split into a reciprocal-multiply stage and a correction stage. A stall
// on the result side holds the unbroken run of occupied stages at the back,
// while an item with an empty stage ahead of it moves on and empty stages keep
// filling. The eight configuration registers are written through the csr_ port
// and should be changed only while no item is in flight.
module deadband_p_drive_control_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_gas_sample,
   input  logic [9:0]  req_steer_sample,
   input  logic [9:0]  req_steer_feedback,
   input  logic [15:0] req_motor_rpm,
   input  logic        req_forward_switch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_throttle_pwm,
   output logic [7:0]  rsp_brake_pump_pwm,
   output logic [7:0]  rsp_steer_right_pwm,
   output logic [7:0]  rsp_steer_left_pwm,
   output logic        rsp_throttle_enable,
   output logic        rsp_regen_brake_enable,
   output logic        rsp_direction_forward,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import dpdc_pkg::*;

   cfg_type               cfg_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;
   stage_en_type          en;
   front_result_type      front_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gas_center            <= GAS_CENTER_RST;
         cfg_ff.steer_center          <= STEER_CENTER_RST;
         cfg_ff.steer_feedback_center <= STEER_FEEDBACK_CENTER_RST;
         cfg_ff.throttle_deadband     <= THROTTLE_DEADBAND_RST;
         cfg_ff.brake_deadband        <= BRAKE_DEADBAND_RST;
         cfg_ff.steer_deadband        <= STEER_DEADBAND_RST;
         cfg_ff.throttle_gain         <= THROTTLE_GAIN_RST;
         cfg_ff.steer_gain            <= STEER_GAIN_RST;
      end else if (csr_write) begin
         unique case (cfg_index_type'(csr_index))
            IDX_GAS_CENTER:            cfg_ff.gas_center            <= csr_wdata;
            IDX_STEER_CENTER:          cfg_ff.steer_center          <= csr_wdata;
            IDX_STEER_FEEDBACK_CENTER: cfg_ff.steer_feedback_center <= csr_wdata;
            IDX_THROTTLE_DEADBAND:     cfg_ff.throttle_deadband <= csr_wdata[CFG8_WIDTH-1:0];
            IDX_BRAKE_DEADBAND:        cfg_ff.brake_deadband    <= csr_wdata[CFG8_WIDTH-1:0];
            IDX_STEER_DEADBAND:        cfg_ff.steer_deadband    <= csr_wdata[CFG8_WIDTH-1:0];
            IDX_THROTTLE_GAIN:         cfg_ff.throttle_gain     <= csr_wdata[CFG8_WIDTH-1:0];
            IDX_STEER_GAIN:            cfg_ff.steer_gain        <= csr_wdata[CFG8_WIDTH-1:0];
         endcase
      end
   end

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_ff & ~ready) | (valid_in & ready);
      end
   end

   assign en.a = ready[0];
   assign en.b = ready[1];
   assign en.c = ready[2];
   assign en.d = ready[3];
   assign en.e = ready[4];
   assign en.f = ready[5];
   assign en.g = ready[6];
   assign en.o = ready[7];

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   dpdc_front u_front (
      .clock          (clock),
      .en             (en),
      .cfg            (cfg_ff),
      .gas_sample     (req_gas_sample),
      .steer_sample   (req_steer_sample),
      .steer_feedback (req_steer_feedback),
      .motor_rpm      (req_motor_rpm),
      .forward_switch (req_forward_switch),
      .res            (front_res)
   );

   dpdc_back u_back (
      .clock              (clock),
      .en                 (en),
      .cfg                (cfg_ff),
      .res                (front_res),
      .throttle_pwm       (rsp_throttle_pwm),
      .brake_pump_pwm     (rsp_brake_pump_pwm),
      .steer_right_pwm    (rsp_steer_right_pwm),
      .steer_left_pwm     (rsp_steer_left_pwm),
      .throttle_enable    (rsp_throttle_enable),
      .regen_brake_enable (rsp_regen_brake_enable),
      .direction_forward  (rsp_direction_forward)
   );
endmodule
`default_nettype wire
